// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file uoe_checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/uoe_pkg.sv
// ---------------------------------------------------------------------------
// uoe_pkg
// Types, constants and character helpers of the URL origin extractor.
// ---------------------------------------------------------------------------
package uoe_pkg;

	localparam int HOST_MAX = 32;
	localparam int HIDX_W   = (HOST_MAX > 1) ? $clog2(HOST_MAX) : 1;
	localparam int HLEN_W   = $clog2(HOST_MAX + 1);
	localparam int PORT_DIG_MAX = 5;

	localparam logic [15:0] PORT_HTTP  = 16'd80;
	localparam logic [15:0] PORT_HTTPS = 16'd443;
	localparam logic [19:0] PORT_LIMIT = 20'd65535;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [3:0] DIGIT_HI = 4'h3;

	typedef enum logic [2:0] {
		SRC_NONE   = 3'd0,
		SRC_SCHEME = 3'd1,
		SRC_SEP    = 3'd2,
		SRC_HOST   = 3'd3,
		SRC_COLON  = 3'd4,
		SRC_DIGIT  = 3'd5
	} src_t;

	typedef struct packed {
		logic parse_en;
		logic clear;
		logic emit;
		src_t src;
		logic ok_item;
		logic last;
		logic cnt_clr;
		logic cnt_inc;
		logic host_inc;
	} uoe_cmd_t;

	typedef struct packed {
		logic ok;
		logic scheme_last;
		logic sep_last;
		logic host_last;
		logic port_show;
		logic digit_last;
		logic out_free;
	} uoe_stat_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_host_char(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			c == CH_DASH || c == CH_DOT || c == CH_UNDER;
	endfunction

	function automatic logic [7:0] scheme_char(input logic [2:0] i);
		logic [7:0] ch;
		case (i)
			3'd0: ch = "h";
			3'd1: ch = "t";
			3'd2: ch = "t";
			3'd3: ch = "p";
			3'd4: ch = "s";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: sv/url_origin_extractor.sv
// ---------------------------------------------------------------------------
// url_origin_extractor
// Reads a URL byte by byte and serializes the origin of an http/https URL.
// ---------------------------------------------------------------------------
// Takes one URL byte per cycle while parsing; the byte with url_end set closes
// the URL. In the next cycle the block has its verdict and then emits one result
// item per cycle (fewer if out_ready is low): either a single reject item or
// the lowercase scheme, "://", the lowercase host and, for a non-default port,
// ":" and the port digits. The host store is read one entry per cycle with its
// next entry prefetched, and input is held off from the final byte until the
// last item is loaded into the output register.
module url_origin_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] url_byte,
	input  logic       url_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] origin_char,
	output logic       accepted,
	output logic       run_end
);
	import uoe_pkg::*;

	uoe_cmd_t  cmd;
	uoe_stat_t stat;

	uoe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.url_end  (url_end),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	uoe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.url_byte    (url_byte),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.origin_char (origin_char),
		.accepted    (accepted),
		.run_end     (run_end)
	);

endmodule

// File: sv/uoe_dp.sv
// ---------------------------------------------------------------------------
// uoe_dp
// Datapath: URL parse state, host store, port digits, output register.
// ---------------------------------------------------------------------------
module uoe_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        url_byte,
	input  uoe_pkg::uoe_cmd_t cmd,
	output uoe_pkg::uoe_stat_t stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [7:0]        origin_char,
	output logic              accepted,
	output logic              run_end
);
	import uoe_pkg::*;

	typedef enum logic [3:0] {
		PH_SCHEME = 4'b0001,
		PH_SLASH  = 4'b0010,
		PH_AUTH   = 4'b0100,
		PH_PATH   = 4'b1000
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [2:0]        scount_q, scount_d;
	logic              smis_q, smis_d;
	logic [1:0]        slash_q, slash_d;
	logic [HLEN_W-1:0] hlen_q, hlen_d;
	logic [15:0]       pval_q, pval_d;
	logic [2:0]        pdig_q, pdig_d;
	logic [2:0]        psig_q, psig_d;
	logic              colon_q, colon_d;
	logic              rej_q, rej_d;

	logic [7:0]        lc;
	logic [3:0]        dval;
	logic [19:0]       pnext;
	logic              host_we, dig_we;

	logic [7:0]        host_mem [HOST_MAX];
	logic [7:0]        host_rd_q;
	logic [HIDX_W-1:0] host_ra;
	logic [3:0]        dig_q [PORT_DIG_MAX];

	logic [2:0]        cnt_q;
	logic [HIDX_W-1:0] hidx_q;
	logic [7:0]        char_mux;
	logic              secure;
	logic              out_valid_q, accepted_q, run_end_q;
	logic [7:0]        origin_char_q;

	assign lc    = to_lower(url_byte);
	assign dval  = url_byte[3:0];
	assign pnext = ({4'b0, pval_q} << 3) + ({4'b0, pval_q} << 1) + {16'b0, dval};

	always_comb begin
		phase_d  = phase_q;
		scount_d = scount_q;
		smis_d   = smis_q;
		slash_d  = slash_q;
		hlen_d   = hlen_q;
		pval_d   = pval_q;
		pdig_d   = pdig_q;
		psig_d   = psig_q;
		colon_d  = colon_q;
		rej_d    = rej_q;
		host_we  = 1'b0;
		dig_we   = 1'b0;
		if (cmd.parse_en && !rej_q) begin
			case (phase_q)
				PH_SCHEME: begin
					if (url_byte == CH_COLON) begin
						if ((scount_q == 3'd4 || scount_q == 3'd5) && !smis_q)
							phase_d = PH_SLASH;
						else
							rej_d = 1'b1;
					end else begin
						if (!(scount_q < 3'd5 && lc == scheme_char(scount_q)))
							smis_d = 1'b1;
						if (scount_q < 3'd6)
							scount_d = scount_q + 3'd1;
					end
				end
				PH_SLASH: begin
					if (url_byte == CH_SLASH) begin
						slash_d = slash_q + 2'd1;
						if (slash_q == 2'd1)
							phase_d = PH_AUTH;
					end else begin
						rej_d = 1'b1;
					end
				end
				PH_AUTH: begin
					if (url_byte == CH_SLASH) begin
						phase_d = PH_PATH;
					end else if (colon_q) begin
						if (is_digit(url_byte) && pdig_q < 3'(PORT_DIG_MAX)) begin
							if (pnext > PORT_LIMIT) begin
								rej_d = 1'b1;
							end else begin
								pval_d = pnext[15:0];
								pdig_d = pdig_q + 3'd1;
								// drop leading zeros, keep significant digits only
								if (pval_q != 16'd0 || dval != 4'd0) begin
									dig_we = 1'b1;
									psig_d = psig_q + 3'd1;
								end
							end
						end else begin
							rej_d = 1'b1;
						end
					end else if (url_byte == CH_COLON) begin
						if (hlen_q == '0)
							rej_d = 1'b1;
						else
							colon_d = 1'b1;
					end else if (is_host_char(url_byte) && hlen_q < HLEN_W'(HOST_MAX)) begin
						host_we = 1'b1;
						hlen_d  = hlen_q + HLEN_W'(1);
					end else begin
						rej_d = 1'b1;
					end
				end
				PH_PATH: ;
				default: ;
			endcase
		end
		if (cmd.clear) begin
			phase_d  = PH_SCHEME;
			scount_d = '0;
			smis_d   = 1'b0;
			slash_d  = '0;
			hlen_d   = '0;
			pval_d   = '0;
			pdig_d   = '0;
			psig_d   = '0;
			colon_d  = 1'b0;
			rej_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SCHEME;
			scount_q <= '0;
			smis_q   <= 1'b0;
			slash_q  <= '0;
			hlen_q   <= '0;
			pval_q   <= '0;
			pdig_q   <= '0;
			psig_q   <= '0;
			colon_q  <= 1'b0;
			rej_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			scount_q <= scount_d;
			smis_q   <= smis_d;
			slash_q  <= slash_d;
			hlen_q   <= hlen_d;
			pval_q   <= pval_d;
			pdig_q   <= pdig_d;
			psig_q   <= psig_d;
			colon_q  <= colon_d;
			rej_q    <= rej_d;
		end
	end

	// host store; read address runs one entry ahead so data is ready on advance
	assign host_ra = cmd.host_inc ? hidx_q + HIDX_W'(1) : hidx_q;

	always_ff @(posedge clk) begin
		if (host_we)
			host_mem[hlen_q[HIDX_W-1:0]] <= lc;
		host_rd_q <= host_mem[host_ra];
	end

	always_ff @(posedge clk) begin
		if (dig_we)
			dig_q[psig_q] <= dval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hidx_q <= '0;
		end else begin
			if (cmd.clear || cmd.cnt_clr)
				cnt_q <= '0;
			else if (cmd.cnt_inc)
				cnt_q <= cnt_q + 3'd1;
			if (cmd.clear)
				hidx_q <= '0;
			else if (cmd.host_inc)
				hidx_q <= hidx_q + HIDX_W'(1);
		end
	end

	assign secure = scount_q == 3'd5;

	always_comb begin
		stat.ok = !rej_q && (phase_q == PH_AUTH || phase_q == PH_PATH) && hlen_q != '0 &&
			(!colon_q || (pdig_q != 3'd0 && pval_q != 16'd0));
		stat.scheme_last = cnt_q == (secure ? 3'd4 : 3'd3);
		stat.sep_last    = cnt_q == 3'd2;
		stat.host_last   = HLEN_W'(hidx_q) + HLEN_W'(1) == hlen_q;
		stat.port_show   = colon_q && pval_q != (secure ? PORT_HTTPS : PORT_HTTP);
		stat.digit_last  = cnt_q + 3'd1 == psig_q;
		stat.out_free    = !out_valid_q || out_ready;
	end

	always_comb begin
		case (cmd.src)
			SRC_SCHEME: char_mux = scheme_char(cnt_q);
			SRC_SEP:    char_mux = (cnt_q == 3'd0) ? CH_COLON : CH_SLASH;
			SRC_HOST:   char_mux = host_rd_q;
			SRC_COLON:  char_mux = CH_COLON;
			SRC_DIGIT:  char_mux = {DIGIT_HI, dig_q[cnt_q]};
			default:    char_mux = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			origin_char_q <= char_mux;
			accepted_q    <= cmd.ok_item;
			run_end_q     <= cmd.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign origin_char = origin_char_q;
	assign accepted    = accepted_q;
	assign run_end     = run_end_q;

endmodule

// File: sv/uoe_ctrl.sv
// ---------------------------------------------------------------------------
// uoe_ctrl
// Controller: byte intake, verdict, and sequencing of the origin items.
// ---------------------------------------------------------------------------
module uoe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               url_end,
	output logic               in_ready,
	input  uoe_pkg::uoe_stat_t stat,
	output uoe_pkg::uoe_cmd_t  cmd
);
	import uoe_pkg::*;

	typedef enum logic [7:0] {
		ST_PARSE  = 8'b0000_0001,
		ST_PREP   = 8'b0000_0010,
		ST_REJECT = 8'b0000_0100,
		ST_SCHEME = 8'b0000_1000,
		ST_SEP    = 8'b0001_0000,
		ST_HOST   = 8'b0010_0000,
		ST_COLON  = 8'b0100_0000,
		ST_DIGIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = state_q == ST_PARSE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.src = SRC_NONE;
		case (state_q)
			ST_PARSE: begin
				if (in_valid) begin
					cmd.parse_en = 1'b1;
					if (url_end)
						state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.cnt_clr = 1'b1;
				state_d = stat.ok ? ST_SCHEME : ST_REJECT;
			end
			ST_REJECT: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.last  = 1'b1;
					cmd.clear = 1'b1;
					state_d   = ST_PARSE;
				end
			end
			ST_SCHEME: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.ok_item = 1'b1;
					cmd.src     = SRC_SCHEME;
					if (stat.scheme_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_SEP;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			ST_SEP: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.ok_item = 1'b1;
					cmd.src     = SRC_SEP;
					if (stat.sep_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_HOST;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			ST_HOST: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.ok_item  = 1'b1;
					cmd.src      = SRC_HOST;
					cmd.host_inc = 1'b1;
					if (stat.host_last) begin
						if (stat.port_show) begin
							state_d = ST_COLON;
						end else begin
							cmd.last  = 1'b1;
							cmd.clear = 1'b1;
							state_d   = ST_PARSE;
						end
					end
				end
			end
			ST_COLON: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.ok_item = 1'b1;
					cmd.src     = SRC_COLON;
					state_d     = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.ok_item = 1'b1;
					cmd.src     = SRC_DIGIT;
					if (stat.digit_last) begin
						cmd.last  = 1'b1;
						cmd.clear = 1'b1;
						state_d   = ST_PARSE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_PARSE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_PARSE;
		else
			state_q <= state_d;
	end

endmodule

// File: sv/uoe_checker.sv
// ---------------------------------------------------------------------------
// uoe_checker
// Port-level checks of the URL origin extractor, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module uoe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] url_byte,
	input logic       url_end,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] origin_char,
	input logic       accepted,
	input logic       run_end
);

	// a reject is always a lone item carrying zero
	`ASSERT_IMPL(a_reject_alone, clk, arst_n, out_valid && !accepted, run_end && origin_char == 8'h00, "reject item malformed")

	// only accepted runs have items before the last one
	`ASSERT_IMPL(a_mid_accepted, clk, arst_n, out_valid && !run_end, accepted, "rejected run continues")

	// the final byte of a URL closes intake for at least the verdict cycle
	`ASSERT_NEXT(a_end_stalls, clk, arst_n, in_valid && in_ready && url_end, !in_ready, "input taken after final byte")

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(origin_char) && $stable(run_end), "stalled result changed")

endmodule

bind url_origin_extractor uoe_checker u_uoe_checker (.*);
